// ===== sv/modbus_read_request_framer_defines.svh =====
// assertion macros shared by the framer rtl
`ifndef MODBUS_READ_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_READ_REQUEST_FRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MBRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MBRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mbrf_pkg.sv =====
package mbrf_pkg;

  localparam int FRAME_LENGTH = 8;
  localparam int CRC_SPAN     = FRAME_LENGTH - 2;
  localparam int CRC_BITS     = CRC_SPAN * 8;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGISTER_COUNT = 2'd1;

  localparam logic [7:0]  FUNCTION_CODE_RST  = 8'h03;
  localparam logic [15:0] REGISTER_COUNT_RST = 16'h0002;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] register_address;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_slave;
    logic [7:0] frame_function;
    logic [7:0] frame_addr_high;
    logic [7:0] frame_addr_low;
    logic [7:0] frame_count_high;
    logic [7:0] frame_count_low;
    logic [7:0] frame_crc_low;
    logic [7:0] frame_crc_high;
  } out_t;

  typedef logic [CRC_BITS-1:0][15:0] crc_cols_t;

  // bit-serial crc, only ever evaluated on constants
  function automatic logic [15:0] crc_serial(input logic [15:0] seed,
                                             input logic [CRC_BITS-1:0] data);
    logic [15:0] crc;
    crc = seed;
    for (int p = 0; p < CRC_SPAN; p++) begin
      crc = crc ^ {8'h00, data[p*8 +: 8]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  // contribution of each message bit; bit 8*p+b is bit b of frame byte p
  function automatic crc_cols_t crc_columns();
    crc_cols_t cols;
    for (int k = 0; k < CRC_BITS; k++) begin
      cols[k] = crc_serial(16'h0000, CRC_BITS'(1) << k);
    end
    return cols;
  endfunction

  localparam crc_cols_t   CRC_COLS = crc_columns();
  localparam logic [15:0] CRC_SEED_TERM = crc_serial(CRC_INIT, '0);

endpackage

// ===== sv/modbus_read_request_framer.sv =====
// channel | ports                         | handshake
// --------+-------------------------------+------------------------------------
// input   | start, busy, in_data          | beat taken when start && !busy
// result  | out_valid, out_data           | one-cycle strobe, never stalled
// config  | cfg_we, cfg_index, cfg_wdata  | write on any edge with cfg_we high
//
// one frame per cycle: busy is tied low, a new beat can enter every cycle
// from accept to out_valid a beat passes the input register, then the
// crc xor network feeding the result register
// rst_n is synchronous; it clears the valid flags and loads the register defaults
// the receiver cannot stall, so nothing holds inside the block
`include "modbus_read_request_framer_defines.svh"

module modbus_read_request_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mbrf_pkg::in_t                 in_data,
  output logic                          out_valid,
  output mbrf_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [mbrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbrf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mbrf_pkg::*;

  logic [7:0]  func_r;
  logic [15:0] count_r;
  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        out_valid_r;
  out_t        out_data_r;
  out_t        out_data_nxt;
  logic [CRC_BITS-1:0] msg;
  logic [15:0] crc;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r  <= FUNCTION_CODE_RST;
      count_r <= REGISTER_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FUNCTION_CODE:  func_r  <= cfg_wdata[7:0];
        REG_REGISTER_COUNT: count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_data_r <= in_data;
    end
  end

  // frame bytes 0..5, byte p in bits 8p+7..8p
  assign msg = {count_r[7:0], count_r[15:8],
                s1_data_r.register_address[7:0], s1_data_r.register_address[15:8],
                func_r, s1_data_r.slave_address};

  always_comb begin
    crc = CRC_SEED_TERM;
    for (int k = 0; k < CRC_BITS; k++) begin
      if (msg[k]) begin
        crc = crc ^ CRC_COLS[k];
      end
    end
  end

  always_comb begin
    out_data_nxt.frame_slave      = s1_data_r.slave_address;
    out_data_nxt.frame_function   = func_r;
    out_data_nxt.frame_addr_high  = s1_data_r.register_address[15:8];
    out_data_nxt.frame_addr_low   = s1_data_r.register_address[7:0];
    out_data_nxt.frame_count_high = count_r[15:8];
    out_data_nxt.frame_count_low  = count_r[7:0];
    out_data_nxt.frame_crc_low    = crc[7:0];
    out_data_nxt.frame_crc_high   = crc[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MBRF_ASSERT_NEXT(a_accept_to_stage, start && !busy, s1_valid_r, "accepted beat lost")
  `MBRF_ASSERT_NEXT(a_stage_to_out, s1_valid_r, out_valid_r, "staged beat not strobed")
  `MBRF_ASSERT_NOW(a_no_phantom, out_valid_r, $past(s1_valid_r), "strobe without staged beat")
  `MBRF_ASSERT_NEXT(a_addr_carried, s1_valid_r,
    out_data_r.frame_addr_high == $past(s1_data_r.register_address[15:8]),
    "address high byte mismatch")

endmodule

// ===== verif/modbus_read_request_framer_tb.sv =====
`timescale 1ns / 1ps

module modbus_read_request_framer_tb;
  import mbrf_pkg::*;

  localparam int CLK_HALF_NS   = 2;
  localparam int TIMEOUT_NS    = 1_000_000;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;

  localparam logic [15:0] FRAME_POLY  = 16'hA001;
  localparam logic [15:0] FRAME_SEED  = 16'hFFFF;
  localparam logic [7:0]  FUNC_AT_RST = 8'h03;
  localparam logic [15:0] COUNT_AT_RST = 16'h0002;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic                 set_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [15:0]          cfg_val;
    in_t                  req;
    logic                 pinned;
    out_t                 frame;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // settings out of reset, well known read of two registers
    '{1'b0, REG_FUNCTION_CODE,  16'h0000, 24'h01_0000, 1'b1, 64'h01030000_0002C40B},
    '{1'b1, REG_REGISTER_COUNT, 16'h0001, 24'h01_0000, 1'b1, 64'h01030000_0001840A},
    '{1'b0, REG_FUNCTION_CODE,  16'h0000, 24'h00_0000, 1'b0, 64'h0},
    '{1'b0, REG_FUNCTION_CODE,  16'h0000, 24'hFF_FFFF, 1'b0, 64'h0},
    '{1'b0, REG_FUNCTION_CODE,  16'h0000, 24'hAA_5555, 1'b0, 64'h0},
    '{1'b0, REG_FUNCTION_CODE,  16'h0000, 24'h55_AAAA, 1'b0, 64'h0},
    '{1'b1, REG_FUNCTION_CODE,  16'h0000, 24'h01_1234, 1'b0, 64'h0},
    '{1'b1, REG_FUNCTION_CODE,  16'h00FF, 24'hFF_0000, 1'b0, 64'h0},
    // upper byte of the write must be dropped
    '{1'b1, REG_FUNCTION_CODE,  16'hAB10, 24'h12_FF00, 1'b0, 64'h0},
    '{1'b1, REG_REGISTER_COUNT, 16'h0000, 24'h00_00FF, 1'b0, 64'h0},
    '{1'b1, REG_REGISTER_COUNT, 16'hFFFF, 24'hFF_FFFF, 1'b0, 64'h0},
    '{1'b1, REG_REGISTER_COUNT, 16'h8000, 24'h80_8000, 1'b0, 64'h0},
    '{1'b1, REG_SPARE_2,        16'hFFFF, 24'h01_0001, 1'b0, 64'h0},
    '{1'b1, REG_SPARE_3,        16'h0000, 24'h7F_7FFF, 1'b0, 64'h0},
    '{1'b1, REG_FUNCTION_CODE,  16'h0004, 24'hF7_0100, 1'b0, 64'h0},
    '{1'b1, REG_REGISTER_COUNT, 16'h007D, 24'h11_0080, 1'b0, 64'h0},
    '{1'b0, REG_FUNCTION_CODE,  16'h0000, 24'h01_0001, 1'b0, 64'h0},
    '{1'b0, REG_FUNCTION_CODE,  16'h0000, 24'h02_0002, 1'b0, 64'h0},
    '{1'b1, REG_FUNCTION_CODE,  16'hFF03, 24'hFE_FFFE, 1'b0, 64'h0},
    '{1'b1, REG_REGISTER_COUNT, 16'h0002, 24'h01_0000, 1'b0, 64'h0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_data;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // typed-in expectation rides along with the beat
  logic pinned;
  out_t pinned_frame;

  logic [7:0]  cur_func;
  logic [15:0] cur_count;
  out_t        frames_due[$];
  int          faults;

  modbus_read_request_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  function automatic out_t build_frame(input in_t req, input logic [7:0] fc,
                                       input logic [15:0] cnt);
    logic [7:0]  bytes [6];
    logic [15:0] crc;
    out_t        f;
    bytes[0] = req.slave_address;
    bytes[1] = fc;
    bytes[2] = req.register_address[15:8];
    bytes[3] = req.register_address[7:0];
    bytes[4] = cnt[15:8];
    bytes[5] = cnt[7:0];
    crc = FRAME_SEED;
    for (int p = 0; p < 6; p++) begin
      crc = crc ^ {8'h00, bytes[p]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ FRAME_POLY) : (crc >> 1);
      end
    end
    f.frame_slave      = bytes[0];
    f.frame_function   = bytes[1];
    f.frame_addr_high  = bytes[2];
    f.frame_addr_low   = bytes[3];
    f.frame_count_high = bytes[4];
    f.frame_count_low  = bytes[5];
    f.frame_crc_low    = crc[7:0];
    f.frame_crc_high   = crc[15:8];
    return f;
  endfunction

  // compare what left the block, then log what entered it
  always @(posedge clk) begin : check_frames
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (frames_due.size() == 0) begin
          faults++;
          if (faults <= MAX_REPORTS)
            $display("unexpected frame: got %h", out_data);
        end else begin
          want = frames_due.pop_front();
          if (out_data.frame_slave      !== want.frame_slave      ||
              out_data.frame_function   !== want.frame_function   ||
              out_data.frame_addr_high  !== want.frame_addr_high  ||
              out_data.frame_addr_low   !== want.frame_addr_low   ||
              out_data.frame_count_high !== want.frame_count_high ||
              out_data.frame_count_low  !== want.frame_count_low  ||
              out_data.frame_crc_low    !== want.frame_crc_low    ||
              out_data.frame_crc_high   !== want.frame_crc_high) begin
            faults++;
            if (faults <= MAX_REPORTS)
              $display("frame mismatch: expected %h got %h", want, out_data);
          end
        end
      end
      if (start && !busy)
        frames_due.push_back(pinned ? pinned_frame
                                    : build_frame(in_data, cur_func, cur_count));
    end
  end

  // returns at the edge that takes the beat; start stays high
  task automatic send_request(input in_t req, input logic pin, input out_t frame);
    start        <= 1'b1;
    in_data      <= req;
    pinned       <= pin;
    pinned_frame <= frame;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_frames(input int settle);
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    if (frames_due.size() != 0) faults++;
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    drain_frames(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FUNCTION_CODE:  cur_func = val[7:0];
      REG_REGISTER_COUNT: cur_count = val;
      default: ;
    endcase
  endtask

  initial begin
    int          sent;
    int          n;
    int          k;
    int          burst;
    int          phase_len;
    int          gap;
    logic        steady;
    logic [7:0]  fc;
    logic [15:0] cnt;
    in_t         req;

    faults       = 0;
    cur_func     = FUNC_AT_RST;
    cur_count    = COUNT_AT_RST;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_data      <= '0;
    pinned       <= 1'b0;
    pinned_frame <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].set_cfg)
        write_reg(DIRECTED[r].cfg_idx, DIRECTED[r].cfg_val);
      send_request(DIRECTED[r].req, DIRECTED[r].pinned, DIRECTED[r].frame);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // each phase starts from an idle block with fresh settings
      case ($urandom_range(0, 3))
        0:       fc = 8'h00;
        1:       fc = 8'hFF;
        2:       fc = 8'h03;
        default: fc = 8'($urandom);
      endcase
      write_reg(REG_FUNCTION_CODE, {8'($urandom), fc});
      case ($urandom_range(0, 4))
        0:       cnt = 16'h0000;
        1:       cnt = 16'hFFFF;
        2:       cnt = 16'($urandom_range(1, 125));
        default: cnt = 16'($urandom);
      endcase
      write_reg(REG_REGISTER_COUNT, cnt);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));

      phase_len = $urandom_range(60, 180);
      steady    = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < phase_len && sent < RANDOM_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst && n < phase_len && sent < RANDOM_ITEMS; k++) begin
          case ($urandom_range(0, 7))
            0:       req.slave_address = 8'h00;
            1:       req.slave_address = 8'hFF;
            default: req.slave_address = 8'($urandom);
          endcase
          case ($urandom_range(0, 7))
            0:       req.register_address = 16'h0000;
            1:       req.register_address = 16'hFFFF;
            default: req.register_address = 16'($urandom);
          endcase
          send_request(req, 1'b0, '0);
          n++;
          sent++;
        end
        if (!steady) begin
          gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain_frames(2 * SETTLE_CYCLES);
    if (faults == 0 && frames_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
